>>> rtl/core/rce_pkg.sv
// package for the reference counted entry cache
// holds widths, request/response word types, codes and chain types
// no dependencies
`timescale 1ns / 1ps

package rce_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W : 4;
	localparam int NUM_W  = 16;
	localparam int CNT_W  = 8;

	localparam logic [NUM_W-1:0] NUM_INVALID = '1;
	localparam logic [CNT_W-1:0] CNT_MAX     = '1;

	localparam logic [1:0] KIND_GET = 2'd0;
	localparam logic [1:0] KIND_DUP = 2'd1;
	localparam logic [1:0] KIND_REL = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NEW    = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_DELETE = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [NUM_W-1:0] object_number;
		logic [3:0]       slot_index;
		logic             links_zero;
	} req_t;

	typedef struct packed {
		logic [3:0]       result_slot;
		logic [1:0]       status;
		logic [CNT_W-1:0] count_after;
	} rsp_t;

	typedef struct packed {
		logic hit_seen;
		logic free_seen;
	} scan_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
		logic              del;
	} res_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_UPDATE
	} state_t;

endpackage

>>> rtl/core/rce_cell.sv
// one slot of the entry cache: object number, reference count, match flags
// passes scan and result words along the chain to its neighbor
// depends on rce_pkg
`timescale 1ns / 1ps

module rce_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rce_pkg::SLOT_W-1:0] cell_idx,
	input  rce_pkg::req_t             req_in,
	input  logic                      match_en,
	input  rce_pkg::req_t             cmd,
	input  logic                      upd_en,
	input  logic                      any_hit,
	input  rce_pkg::scan_t            scan_in,
	output rce_pkg::scan_t            scan_out,
	input  rce_pkg::res_t             res_in,
	output rce_pkg::res_t             res_out,
	output logic                      sel
);

	logic [rce_pkg::NUM_W-1:0] num_q;
	logic [rce_pkg::CNT_W-1:0] cnt_q;
	logic                      hit_q;
	logic                      free_q;

	logic                      is_get;
	logic                      is_dup;
	logic                      is_rel;
	logic                      idx_hit;
	logic                      get_hit;
	logic                      claim;
	logic                      del;
	logic [rce_pkg::CNT_W-1:0] cnt_inc;
	logic [rce_pkg::CNT_W-1:0] cnt_dec;
	logic [rce_pkg::CNT_W-1:0] cnt_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (match_en) begin
			hit_q  <= (cnt_q != '0) && (num_q == req_in.object_number);
			free_q <= (cnt_q == '0);
		end
	end

	always_comb begin
		is_get   = (cmd.kind == rce_pkg::KIND_GET);
		is_dup   = (cmd.kind == rce_pkg::KIND_DUP);
		is_rel   = (cmd.kind == rce_pkg::KIND_REL);
		idx_hit  = (rce_pkg::CMP_W'(cmd.slot_index) == rce_pkg::CMP_W'(cell_idx));

		scan_out.hit_seen  = scan_in.hit_seen | hit_q;
		scan_out.free_seen = scan_in.free_seen | free_q;

		get_hit = is_get & hit_q & ~scan_in.hit_seen;
		claim   = is_get & ~any_hit & free_q & ~scan_in.free_seen;
		sel     = get_hit | claim | ((is_dup | is_rel) & idx_hit);

		cnt_inc = (cnt_q == rce_pkg::CNT_MAX) ? cnt_q : cnt_q + rce_pkg::CNT_W'(1);
		cnt_dec = (cnt_q != '0) ? cnt_q - rce_pkg::CNT_W'(1) : cnt_q;
		if (claim) begin
			cnt_new = rce_pkg::CNT_W'(1);
		end else if (is_rel) begin
			cnt_new = cnt_dec;
		end else begin
			cnt_new = cnt_inc;
		end
		del = is_rel & (cnt_new == '0) & cmd.links_zero;

		if (sel) begin
			res_out.found = 1'b1;
			res_out.slot  = cell_idx;
			res_out.count = del ? '0 : cnt_new;
			res_out.del   = del;
		end else begin
			res_out = res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= rce_pkg::NUM_INVALID;
			cnt_q <= '0;
		end else if (upd_en && sel) begin
			cnt_q <= cnt_new;
			if (claim) begin
				num_q <= cmd.object_number;
			end else if (del) begin
				num_q <= rce_pkg::NUM_INVALID;
			end
		end
	end

endmodule

>>> rtl/core/refcounted_entry_cache_unit.sv
// top level of the reference counted entry cache: request control and cell chain
// depends on rce_pkg and rce_cell
//
// usage:
//   a request word (req) is taken at a rising edge with start high and busy low.
//   kind get looks up object_number, dup raises and rel lowers the count of
//   slot_index. one response word (rsp) comes back per request, marked by done
//   for exactly one cycle; the receiver cannot hold it off.
// operation:
//   in the accept cycle every cell compares its own number and count against
//   the request and registers hit and free flags. the next cycle a scan ripples
//   through the chain of cells to pick the lowest hit or free slot, that cell
//   updates and the response is registered. done and the response word are
//   registered together from the update cycle. busy is high for the one update cycle,
//   so no new request is taken while one is being updated.
// reset:
//   arst_n clears all counts to zero, all numbers to all ones and the control.
`timescale 1ns / 1ps

module refcounted_entry_cache_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rce_pkg::req_t req,
	output logic          done,
	output rce_pkg::rsp_t rsp
);

	rce_pkg::state_t state_q;
	rce_pkg::state_t state_d;
	rce_pkg::req_t   cmd_q;
	rce_pkg::rsp_t   rsp_q;
	rce_pkg::rsp_t   rsp_d;
	logic            done_q;
	logic            accept;
	logic            upd_en;

	rce_pkg::scan_t  scan_c [rce_pkg::SLOTS+1];
	rce_pkg::res_t   res_c  [rce_pkg::SLOTS+1];
	logic [rce_pkg::SLOTS-1:0] sel;
	logic            any_hit;
	rce_pkg::res_t   res_end;
	logic [rce_pkg::CMP_W-1:0] slot_wide;

	assign busy   = (state_q == rce_pkg::FSM_UPDATE);
	assign accept = start && !busy;
	assign upd_en = (state_q == rce_pkg::FSM_UPDATE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rce_pkg::FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= upd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		if (upd_en) begin
			rsp_q <= rsp_d;
		end
	end

	assign scan_c[0] = '0;
	assign res_c[0]  = '0;

	for (genvar i = 0; i < rce_pkg::SLOTS; i++) begin : g_cell
		rce_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (rce_pkg::SLOT_W'(i)),
			.req_in   (req),
			.match_en (accept),
			.cmd      (cmd_q),
			.upd_en   (upd_en),
			.any_hit  (any_hit),
			.scan_in  (scan_c[i]),
			.scan_out (scan_c[i+1]),
			.res_in   (res_c[i]),
			.res_out  (res_c[i+1]),
			.sel      (sel[i])
		);
	end

	assign any_hit   = scan_c[rce_pkg::SLOTS].hit_seen;
	assign res_end   = res_c[rce_pkg::SLOTS];
	assign slot_wide = rce_pkg::CMP_W'(res_end.slot);

	always_comb begin
		state_d = state_q;
		rsp_d   = '0;
		case (state_q)
			rce_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = rce_pkg::FSM_UPDATE;
				end
			end
			rce_pkg::FSM_UPDATE: begin
				state_d = rce_pkg::FSM_IDLE;
			end
			default: begin
				state_d = rce_pkg::FSM_IDLE;
			end
		endcase

		case (cmd_q.kind)
			rce_pkg::KIND_GET: begin
				if (res_end.found) begin
					rsp_d.result_slot = slot_wide[3:0];
					rsp_d.status      = any_hit ? rce_pkg::ST_OK : rce_pkg::ST_NEW;
					rsp_d.count_after = res_end.count;
				end else begin
					rsp_d.status = rce_pkg::ST_FULL;
				end
			end
			rce_pkg::KIND_DUP, rce_pkg::KIND_REL: begin
				rsp_d.result_slot = cmd_q.slot_index;
				if (res_end.found) begin
					rsp_d.status      = res_end.del ? rce_pkg::ST_DELETE : rce_pkg::ST_OK;
					rsp_d.count_after = res_end.count;
				end else begin
					rsp_d.status = rce_pkg::ST_FULL;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> done)
		else $error("update cycle produced no response");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response strobe held for two cycles");

	a_one_cell_sel: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |-> $onehot0(sel))
		else $error("more than one cell selected");

endmodule
